// ===== rtl/ps2_keyboard_transmitter_top_assert.svh =====
// Assertion macros for the keyboard transmitter RTL.
`ifndef PS2_KEYBOARD_TRANSMITTER_TOP_ASSERT_SVH
`define PS2_KEYBOARD_TRANSMITTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define PS2KT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define PS2KT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PS2KT_ASSERT(lbl, prop, msg)
`define PS2KT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/ps2kt_pkg.sv =====
// Types and constants of the PS/2 keyboard transmitter.
package ps2kt_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int HALF_W     = 16;
  localparam int POS_W      = 4;

  localparam logic [HALF_W-1:0] HALF_PERIOD_RST = HALF_W'(15);

  localparam logic [7:0] PREFIX_EXT   = 8'hE0;
  localparam logic [7:0] PREFIX_BREAK = 8'hF0;

  localparam logic [POS_W-1:0] POS_START  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_PARITY = POS_W'(9);
  localparam logic [POS_W-1:0] POS_STOP   = POS_W'(10);
  localparam logic [POS_W-1:0] FRAME_BITS = POS_W'(11);

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_KEY  = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] scan_code;
    logic       extended;
    logic       key_down;
  } ps2kt_in_t;

  typedef struct packed {
    logic clock_level;
    logic data_level;
    logic idle;
    logic overflow;
  } ps2kt_out_t;

  // One queued key event; it stands for one to three bytes of the byte stream.
  typedef struct packed {
    logic       ext;
    logic       brk;
    logic [7:0] code;
  } ps2kt_evt_t;

endpackage

// ===== rtl/ps2_keyboard_transmitter_top.sv =====
// Top level of the PS/2 keyboard device-side transmitter.
// This block plays the keyboard end of a PS/2 link. Each accepted item is
// either a key event, which queues its make or break bytes (0xE0 when the key
// is extended, 0xF0 on release, then the scan code), or a time tick, which
// advances the serial transmitter by one step. Every item yields exactly one
// result item holding the clock and data line levels after that item, an idle
// flag and an overflow flag that marks a key event dropped for lack of room.
// Frames are 11 bits: start 0, eight data bits LSB first, odd parity, stop 1;
// data changes on the rising clock edge, and the clock toggles every
// half_period + 1 ticks. The queue holds FIFO_DEPTH bytes; it is kept as one
// entry per key event in a synchronous memory, so a key event costs a single
// write, and the entry at the head is read every cycle at the next head
// address with write forwarding, so the byte to send is ready on the next
// tick. The block takes one item per clock cycle, back to back; a result
// appears in the output register in the cycle after its item is accepted, and
// the input is stalled only while that register holds a result that the
// receiver is stalling. The loop through the head read and the count and
// pointer update sets that rate. half_period may be written only
// while no result is outstanding; a frame in progress takes the new value at
// its next countdown reload.
module ps2_keyboard_transmitter_top
  import ps2kt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ps2kt_in_t         in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ps2kt_out_t        out_data,
  input  logic              cfg_we,
  input  logic [HALF_W-1:0] cfg_wdata
);

`include "ps2_keyboard_transmitter_top_assert.svh"

  // Event memory, one entry per queued key event.
  ps2kt_evt_t mem [FIFO_DEPTH];
  ps2kt_evt_t rd_q;
  ps2kt_evt_t wr_evt;
  logic       mem_we;

  logic [HALF_W-1:0] half_r;

  logic [CNT_W-1:0]  cnt_r,    cnt_nxt;
  logic [PTR_W-1:0]  head_r,   head_nxt;
  logic [PTR_W-1:0]  tail_r,   tail_nxt;
  logic [1:0]        sub_r,    sub_nxt;
  logic [7:0]        shift_r,  shift_nxt;
  logic              parity_r, parity_nxt;
  logic              active_r, active_nxt;
  logic [POS_W-1:0]  pos_r,    pos_nxt;
  logic [HALF_W-1:0] cd_r,     cd_nxt;
  logic              clk_line_r, clk_line_nxt;
  logic              dat_line_r, dat_line_nxt;

  logic              out_valid_r;
  ps2kt_out_t        out_data_r;

  logic              in_acc;
  logic              ovf;
  logic [1:0]        need;
  logic [CNT_W+1:0]  room_sum;
  logic              start;
  logic [HALF_W-1:0] cd_cur;
  logic [7:0]        shift_cur;
  logic [POS_W-1:0]  pos_cur;
  logic [7:0]        head_byte;
  logic              head_last;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  // Byte number sub of the event's byte sequence.
  function automatic logic [7:0] evt_byte(input ps2kt_evt_t e, input logic [1:0] sub);
    if (e.ext && sub == 2'd0) begin
      return PREFIX_EXT;
    end
    if (e.brk && sub == {1'b0, e.ext}) begin
      return PREFIX_BREAK;
    end
    return e.code;
  endfunction

  // Output register decouples the two handshakes; a result waiting while the
  // receiver is not stalling does not hold up the next item.
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign head_byte = evt_byte(rd_q, sub_r);
  assign head_last = (sub_r == (2'({1'b0, rd_q.ext}) + 2'({1'b0, rd_q.brk})));

  assign need     = 2'd1 + 2'({1'b0, in_data.extended}) + 2'({1'b0, !in_data.key_down});
  assign room_sum = (CNT_W+2)'(cnt_r) + (CNT_W+2)'(need);

  assign wr_evt.ext  = in_data.extended;
  assign wr_evt.brk  = !in_data.key_down;
  assign wr_evt.code = in_data.scan_code;

  assign start     = !active_r && (cnt_r != '0);
  assign cd_cur    = start ? half_r : cd_r;
  assign shift_cur = start ? head_byte : shift_r;
  assign pos_cur   = start ? POS_START : pos_r;

  always_comb begin
    cnt_nxt      = cnt_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    sub_nxt      = sub_r;
    shift_nxt    = shift_r;
    parity_nxt   = parity_r;
    active_nxt   = active_r;
    pos_nxt      = pos_r;
    cd_nxt       = cd_r;
    clk_line_nxt = clk_line_r;
    dat_line_nxt = dat_line_r;
    ovf          = 1'b0;
    mem_we       = 1'b0;
    if (in_acc) begin
      if (in_data.operation == OP_KEY) begin
        if (room_sum > (CNT_W+2)'(FIFO_DEPTH)) begin
          ovf = 1'b1;
        end else begin
          mem_we   = 1'b1;
          cnt_nxt  = CNT_W'(room_sum);
          tail_nxt = ptr_inc(tail_r);
        end
      end else if (active_r || start) begin
        active_nxt = 1'b1;
        if (start) begin
          parity_nxt = ~^head_byte;
        end
        if (cd_cur != '0) begin
          cd_nxt    = cd_cur - HALF_W'(1);
          shift_nxt = shift_cur;
          pos_nxt   = pos_cur;
        end else begin
          clk_line_nxt = !clk_line_r;
          cd_nxt       = half_r;
          shift_nxt    = shift_cur;
          pos_nxt      = pos_cur;
          if (!clk_line_r) begin
            // Rising edge: drive the next frame bit.
            unique if (pos_cur == POS_PARITY) begin
              dat_line_nxt = parity_r | (start & ~^head_byte);
            end else if (pos_cur == POS_STOP) begin
              dat_line_nxt = 1'b1;
            end else if (pos_cur >= POS_W'(1) && pos_cur <= POS_W'(8)) begin
              dat_line_nxt = shift_cur[0];
              shift_nxt    = {1'b0, shift_cur[7:1]};
            end else begin
              dat_line_nxt = 1'b0;
            end
            pos_nxt = pos_cur + POS_W'(1);
          end else if (pos_cur == FRAME_BITS) begin
            // Falling edge after the stop bit closes the frame and pops.
            pos_nxt    = POS_START;
            active_nxt = 1'b0;
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - CNT_W'(1);
              if (head_last) begin
                head_nxt = ptr_inc(head_r);
                sub_nxt  = 2'd0;
              end else begin
                sub_nxt = sub_r + 2'd1;
              end
            end
          end
        end
      end
    end
  end

  // Head entry is read at the address it will have next cycle; a write to
  // that same entry in this cycle is forwarded.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= wr_evt;
    end
    rd_q <= (mem_we && tail_r == head_nxt) ? wr_evt : mem[head_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r      <= HALF_PERIOD_RST;
      cnt_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      sub_r       <= 2'd0;
      shift_r     <= '0;
      parity_r    <= 1'b0;
      active_r    <= 1'b0;
      pos_r       <= POS_START;
      cd_r        <= '0;
      clk_line_r  <= 1'b0;
      dat_line_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        half_r <= cfg_wdata;
      end
      cnt_r      <= cnt_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      sub_r      <= sub_nxt;
      shift_r    <= shift_nxt;
      parity_r   <= parity_nxt;
      active_r   <= active_nxt;
      pos_r      <= pos_nxt;
      cd_r       <= cd_nxt;
      clk_line_r <= clk_line_nxt;
      dat_line_r <= dat_line_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r.clock_level <= clk_line_nxt;
      out_data_r.data_level  <= dat_line_nxt;
      out_data_r.idle        <= !active_nxt && (cnt_nxt == '0);
      out_data_r.overflow    <= ovf;
    end
  end

  `PS2KT_ASSERT(a_cnt_bound, (cnt_r <= CNT_W'(FIFO_DEPTH)), "byte count exceeds queue depth")
  `PS2KT_ASSERT(a_frame_has_byte, (active_r |-> cnt_r != '0), "frame running with empty queue")
  `PS2KT_ASSERT(a_pos_bound, (pos_r <= FRAME_BITS), "bit position beyond frame end")
  `PS2KT_ASSERT(a_drop_keeps_cnt, (in_acc && in_data.operation == OP_KEY && ovf |=> $stable(cnt_r)), "dropped key event changed the queue")
  `PS2KT_ASSERT(a_clk_only_on_tick, (!(in_acc && in_data.operation == OP_TICK) |=> $stable(clk_line_r)), "clock line moved without a tick")

endmodule
